// File: rtl/core/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
package bba_pkg;

   localparam int TOP_ORDER       = 10;
   localparam int LEVELS          = TOP_ORDER + 1;
   localparam int LVL_W           = 4;
   localparam int MIN_SHIFT       = 7;
   localparam int MIN_BLOCK_BYTES = 128;
   localparam int UNIT_W          = 15;
   localparam int UNIT_DEPTH      = 32768;
   localparam int BM_AW           = 11;
   localparam int BM_DEPTH        = 2047;
   localparam int SM_AW           = 9;
   localparam int SM_DEPTH        = 352;
   localparam int WORD_W          = 32;
   localparam int NEED_W          = 28;
   localparam int HDR_W           = 11;
   localparam int REQ_W           = 32;
   localparam int ADDR_W          = 22;
   localparam int ORD_W           = 4;
   localparam int STAT_W          = 3;

   localparam logic [HDR_W-1:0]  HDR_RESET   = 11'd56;
   localparam logic [REQ_W-1:0]  MAX_REQUEST = 32'd100000000;
   localparam logic [NEED_W-1:0] TOP_BYTES   = 28'd131072;
   // bitmap word and summary word holding the top-order blocks
   localparam logic [BM_AW-1:0]  BM_TOP_ADDR = 11'd2046;
   localparam logic [SM_AW-1:0]  SM_TOP_ADDR = 9'd320;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_SIZE  = 3'd1,
      STATUS_TOO_LARGE = 3'd2,
      STATUS_NO_BLOCK  = 3'd3,
      STATUS_BAD_FREE  = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      FSM_CLEAR, FSM_IDLE, FSM_CHECK, FSM_FIT, FSM_SRCH, FSM_ASUM, FSM_AWORD,
      FSM_ABM, FSM_ABIT, FSM_SRD, FSM_SWR, FSM_AFIN, FSM_FRD, FSM_FCHK,
      FSM_MRD, FSM_MWR, FSM_TRD, FSM_TWR
   } fsm_state_type;

   // first bitmap word of order k: each level holds half the words of the one below
   function automatic logic [BM_AW-1:0] bm_base(input logic [LVL_W-1:0] k);
      logic [BM_AW:0] full;
      full = 12'd2048;
      return BM_AW'(full - (full >> k));
   endfunction

endpackage

// File: rtl/core/buddy_block_allocator_unit.sv
// Buddy block allocator: 32 top blocks of 128 KiB, orders 128 B to 128 KiB.
//
// Requests enter on start while busy is low: req_action 0 allocates
// req_request_bytes (plus the header_bytes register), 1 frees the block at
// req_block_address. Each item gives exactly one result, shown for one cycle
// with rsp_strobe; the receiver takes it at once and cannot stall it.
// The header register is written over the csr_ channel; csr_ready is always high.
// State lives in three one-port-read memories: a free bitmap per order (32-bit
// words), a summary bitmap of nonempty words per order, and a per-unit
// allocated flag with order. A register per order marks nonempty summary words.
// Each item works by read-modify-write on the bitmap memories:
//   allocate: size check, fit, search, take a block, one read-write per split level;
//   free: alignment and flag check, one read-write per merge level; both may reject early.
// One item at a time; busy stays high until its result strobe.
// After reset a clearing pass over all 32768 units initializes all memories,
// with busy high; csr writes are still taken.
module buddy_block_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [bba_pkg::REQ_W-1:0]       req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]      req_block_address,
   output logic                            rsp_strobe,
   output logic [bba_pkg::STAT_W-1:0]      rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [bba_pkg::ORD_W-1:0]       rsp_granted_order,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bba_pkg::HDR_W-1:0]       csr_header_bytes
);

   localparam int WW = bba_pkg::WORD_W;
   localparam int UW = bba_pkg::UNIT_W;
   localparam int LW = bba_pkg::LVL_W;

   bba_pkg::fsm_state_type state_ff, state_in;

   logic [UW-1:0]                  clr_ff, clr_in;
   logic [bba_pkg::HDR_W-1:0]      hdr_ff;
   logic [bba_pkg::REQ_W-1:0]      req_ff, req_in;
   logic [bba_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [bba_pkg::NEED_W-1:0]     need_ff, need_in;
   logic [LW-1:0]                  t_ff, t_in;
   logic [LW-1:0]                  lvl_ff, lvl_in;
   logic [UW-1:0]                  idx_ff, idx_in;
   logic [UW-1:0]                  pos_ff, pos_in;
   logic [WW-1:0]                  smd_ff, smd_in;
   logic [WW-1:0]                  top_ff [bba_pkg::LEVELS];
   logic                           top_set, top_clr;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [bba_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [bba_pkg::ORD_W-1:0]      rsp_order_ff, rsp_order_in;

   // memories
   logic [WW-1:0]                  bm_mem [bba_pkg::BM_DEPTH];
   logic [WW-1:0]                  sm_mem [bba_pkg::SM_DEPTH];
   logic [LW:0]                    um_mem [bba_pkg::UNIT_DEPTH];
   logic [WW-1:0]                  bm_rd_ff, sm_rd_ff;
   logic [LW:0]                    um_rd_ff;
   logic [bba_pkg::BM_AW-1:0]      bm_addr, bm_wa;
   logic [bba_pkg::SM_AW-1:0]      sm_addr, sm_wa;
   logic [UW-1:0]                  um_ra, um_wa;
   logic [WW-1:0]                  bm_wd, sm_wd;
   logic [LW:0]                    um_wd;
   logic                           bm_we, sm_we, um_we;

   // combinational helpers
   logic [LW-1:0]                  fit_t, find_i;
   logic                           found;
   logic [4:0]                     top_lsb, sm_lsb, bm_lsb;
   logic [WW-1:0]                  bm_clr_word, sm_clr_word;
   logic [UW-1:0]                  hit_idx, unit, nidx;
   logic [LW-1:0]                  ord;

   function automatic logic [4:0] lsb32(input logic [WW-1:0] v);
      logic [4:0] r;
      r = '0;
      for (int b = WW - 1; b >= 0; b--) begin
         if (v[b]) r = 5'(b);
      end
      return r;
   endfunction

   assign busy                = (state_ff != bba_pkg::FSM_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_order   = rsp_order_ff;

   assign bm_addr = bba_pkg::bm_base(lvl_ff) + bba_pkg::BM_AW'(pos_ff[UW-1:5]);
   assign sm_addr = {lvl_ff, pos_ff[UW-1:10]};
   assign um_ra   = addr_ff[bba_pkg::ADDR_W-1:bba_pkg::MIN_SHIFT];
   assign unit    = addr_ff[bba_pkg::ADDR_W-1:bba_pkg::MIN_SHIFT];

   // smallest order that holds the request plus header
   always_comb begin
      fit_t = LW'(bba_pkg::TOP_ORDER);
      for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
         if (need_ff <= (bba_pkg::NEED_W'(bba_pkg::MIN_BLOCK_BYTES) << k)) fit_t = LW'(k);
      end
   end

   // lowest order at or above the fit with any free block
   always_comb begin
      find_i = '0;
      found  = 1'b0;
      for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
         if (LW'(k) >= t_ff && top_ff[k] != '0) begin
            find_i = LW'(k);
            found  = 1'b1;
         end
      end
   end

   assign top_lsb     = lsb32(top_ff[find_i]);
   assign sm_lsb      = lsb32(sm_rd_ff);
   assign bm_lsb      = lsb32(bm_rd_ff);
   assign ord         = (um_rd_ff[LW-1:0] > LW'(bba_pkg::TOP_ORDER)) ?
                        LW'(bba_pkg::TOP_ORDER) : um_rd_ff[LW-1:0];
   assign nidx        = idx_ff >> 1;
   assign hit_idx     = {pos_ff[UW-1:5], bm_lsb};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      t_in          = t_ff;
      lvl_in        = lvl_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      smd_in        = smd_ff;
      top_set       = 1'b0;
      top_clr       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_order_in  = rsp_order_ff;
      bm_we         = 1'b0;
      bm_wa         = bm_addr;
      bm_wd         = '0;
      sm_we         = 1'b0;
      sm_wa         = sm_addr;
      sm_wd         = '0;
      um_we         = 1'b0;
      um_wa         = unit;
      um_wd         = '0;
      bm_clr_word   = '0;
      sm_clr_word   = '0;

      unique case (state_ff)
         bba_pkg::FSM_CLEAR: begin
            um_we  = 1'b1;
            um_wa  = clr_ff;
            bm_wa  = clr_ff[bba_pkg::BM_AW-1:0];
            bm_we  = (clr_ff < UW'(bba_pkg::BM_DEPTH));
            bm_wd  = (bm_wa == bba_pkg::BM_TOP_ADDR) ? '1 : '0;
            sm_wa  = clr_ff[bba_pkg::SM_AW-1:0];
            sm_we  = (clr_ff < UW'(bba_pkg::SM_DEPTH));
            sm_wd  = (sm_wa == bba_pkg::SM_TOP_ADDR) ? WW'(1) : '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == UW'(bba_pkg::UNIT_DEPTH - 1)) state_in = bba_pkg::FSM_IDLE;
         end
         bba_pkg::FSM_IDLE: begin
            if (start) begin
               req_in   = req_request_bytes;
               addr_in  = req_block_address;
               state_in = req_action ? bba_pkg::FSM_FRD : bba_pkg::FSM_CHECK;
            end
         end
         bba_pkg::FSM_CHECK: begin
            if (req_ff == '0 || req_ff > bba_pkg::MAX_REQUEST) begin
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_BAD_SIZE;
               rsp_addr_in   = '0;
               rsp_order_in  = '0;
            end else begin
               need_in  = bba_pkg::NEED_W'(req_ff) + bba_pkg::NEED_W'(hdr_ff);
               state_in = bba_pkg::FSM_FIT;
            end
         end
         bba_pkg::FSM_FIT: begin
            if (need_ff > bba_pkg::TOP_BYTES) begin
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_TOO_LARGE;
               rsp_addr_in   = '0;
               rsp_order_in  = '0;
            end else begin
               t_in     = fit_t;
               state_in = bba_pkg::FSM_SRCH;
            end
         end
         bba_pkg::FSM_SRCH: begin
            if (!found) begin
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_NO_BLOCK;
               rsp_addr_in   = '0;
               rsp_order_in  = '0;
            end else begin
               lvl_in   = find_i;
               pos_in   = {top_lsb, 10'd0};
               state_in = bba_pkg::FSM_ASUM;
            end
         end
         bba_pkg::FSM_ASUM: state_in = bba_pkg::FSM_AWORD;
         bba_pkg::FSM_AWORD: begin
            smd_in      = sm_rd_ff;
            pos_in[9:5] = sm_lsb;
            state_in    = bba_pkg::FSM_ABM;
         end
         bba_pkg::FSM_ABM: state_in = bba_pkg::FSM_ABIT;
         bba_pkg::FSM_ABIT: begin
            // take the block, then drop emptied words from the summaries
            bm_clr_word = bm_rd_ff & ~(WW'(1) << bm_lsb);
            bm_we       = 1'b1;
            bm_wd       = bm_clr_word;
            sm_clr_word = smd_ff & ~(WW'(1) << pos_ff[9:5]);
            if (bm_clr_word == '0) begin
               sm_we   = 1'b1;
               sm_wd   = sm_clr_word;
               top_clr = (sm_clr_word == '0);
            end
            if (lvl_ff == t_ff) begin
               idx_in   = hit_idx;
               state_in = bba_pkg::FSM_AFIN;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               idx_in   = hit_idx << 1;
               pos_in   = (hit_idx << 1) | UW'(1);
               state_in = bba_pkg::FSM_SRD;
            end
         end
         bba_pkg::FSM_SRD: state_in = bba_pkg::FSM_SWR;
         bba_pkg::FSM_SWR: begin
            // upper half of the split becomes free
            bm_we   = 1'b1;
            bm_wd   = bm_rd_ff | (WW'(1) << pos_ff[4:0]);
            sm_we   = 1'b1;
            sm_wd   = sm_rd_ff | (WW'(1) << pos_ff[9:5]);
            top_set = 1'b1;
            if (lvl_ff == t_ff) begin
               state_in = bba_pkg::FSM_AFIN;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               idx_in   = idx_ff << 1;
               pos_in   = (idx_ff << 1) | UW'(1);
               state_in = bba_pkg::FSM_SRD;
            end
         end
         bba_pkg::FSM_AFIN: begin
            um_we         = 1'b1;
            um_wa         = UW'(idx_ff << t_ff);
            um_wd         = {1'b1, t_ff};
            state_in      = bba_pkg::FSM_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = bba_pkg::STATUS_OK;
            rsp_addr_in   = {um_wa, bba_pkg::MIN_SHIFT'(0)};
            rsp_order_in  = t_ff;
         end
         bba_pkg::FSM_FRD: begin
            if (addr_ff[bba_pkg::MIN_SHIFT-1:0] != '0) begin
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_BAD_FREE;
               rsp_addr_in   = '0;
               rsp_order_in  = '0;
            end else begin
               state_in = bba_pkg::FSM_FCHK;
            end
         end
         bba_pkg::FSM_FCHK: begin
            if (!um_rd_ff[LW]) begin
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_BAD_FREE;
               rsp_addr_in   = '0;
               rsp_order_in  = '0;
            end else begin
               um_we  = 1'b1;
               um_wd  = '0;
               t_in   = ord;
               lvl_in = ord;
               idx_in = unit >> ord;
               if (ord == LW'(bba_pkg::TOP_ORDER)) begin
                  pos_in   = unit >> ord;
                  state_in = bba_pkg::FSM_TRD;
               end else begin
                  pos_in   = (unit >> ord) ^ UW'(1);
                  state_in = bba_pkg::FSM_MRD;
               end
            end
         end
         bba_pkg::FSM_MRD: state_in = bba_pkg::FSM_MWR;
         bba_pkg::FSM_MWR: begin
            if (bm_rd_ff[pos_ff[4:0]]) begin
               // buddy free: absorb it and climb one order
               bm_clr_word = bm_rd_ff & ~(WW'(1) << pos_ff[4:0]);
               bm_we       = 1'b1;
               bm_wd       = bm_clr_word;
               sm_clr_word = sm_rd_ff & ~(WW'(1) << pos_ff[9:5]);
               if (bm_clr_word == '0) begin
                  sm_we   = 1'b1;
                  sm_wd   = sm_clr_word;
                  top_clr = (sm_clr_word == '0);
               end
               idx_in = nidx;
               lvl_in = lvl_ff + 1'b1;
               if (lvl_ff == LW'(bba_pkg::TOP_ORDER - 1)) begin
                  pos_in   = nidx;
                  state_in = bba_pkg::FSM_TRD;
               end else begin
                  pos_in   = nidx ^ UW'(1);
                  state_in = bba_pkg::FSM_MRD;
               end
            end else begin
               // buddy busy: own block shares the word, mark it free here
               bm_we         = 1'b1;
               bm_wd         = bm_rd_ff | (WW'(1) << idx_ff[4:0]);
               sm_we         = 1'b1;
               sm_wd         = sm_rd_ff | (WW'(1) << pos_ff[9:5]);
               top_set       = 1'b1;
               state_in      = bba_pkg::FSM_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_OK;
               rsp_addr_in   = '0;
               rsp_order_in  = t_ff;
            end
         end
         bba_pkg::FSM_TRD: state_in = bba_pkg::FSM_TWR;
         bba_pkg::FSM_TWR: begin
            bm_we         = 1'b1;
            bm_wd         = bm_rd_ff | (WW'(1) << pos_ff[4:0]);
            sm_we         = 1'b1;
            sm_wd         = sm_rd_ff | (WW'(1) << pos_ff[9:5]);
            top_set       = 1'b1;
            state_in      = bba_pkg::FSM_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = bba_pkg::STATUS_OK;
            rsp_addr_in   = '0;
            rsp_order_in  = t_ff;
         end
         default: state_in = bba_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         hdr_ff        <= bba_pkg::HDR_RESET;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < bba_pkg::LEVELS; k++) begin
            top_ff[k] <= (k == bba_pkg::TOP_ORDER) ? WW'(1) : '0;
         end
      end else begin
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) hdr_ff <= csr_header_bytes;
         if (top_set) top_ff[lvl_ff][pos_ff[UW-1:10]] <= 1'b1;
         else if (top_clr) top_ff[lvl_ff][pos_ff[UW-1:10]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      t_ff          <= t_in;
      lvl_ff        <= lvl_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      smd_ff        <= smd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_order_ff  <= rsp_order_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_wa] <= bm_wd;
      bm_rd_ff <= bm_mem[bm_addr];
   end

   always_ff @(posedge clock) begin
      if (sm_we) sm_mem[sm_wa] <= sm_wd;
      sm_rd_ff <= sm_mem[sm_addr];
   end

   always_ff @(posedge clock) begin
      if (um_we) um_mem[um_wa] <= um_wd;
      um_rd_ff <= um_mem[um_ra];
   end

endmodule
